// ===== rtl/sbc_pkg.sv =====
`default_nettype none
package sbc_pkg;

    // fixed field widths
    localparam int SPEED_W = 10;
    localparam int DUTY_W  = 10;
    localparam int PHASE_W = 2;
    localparam int STEP_W  = 3;
    localparam int MATCH_W = 8;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // parameter defaults
    localparam int DEF_DUTY_BITS  = 10;
    localparam int DEF_DELAY_BITS = 16;

    // register reset values
    localparam int RST_MIN_DUTY   = 80;
    localparam int RST_START_DUTY = 200;
    localparam int RST_RAMP_INIT  = 5000;
    localparam int RST_RAMP_DEC   = 50;
    localparam int RST_RAMP_END   = 100;
    localparam int RST_DEBOUNCE   = 10;

    localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_A    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_B    = 2'd1;
    localparam logic [PHASE_W-1:0] PH_C    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_NONE = 2'd3;

    typedef enum logic [2:0] {
        REG_MIN_DUTY   = 3'd0,
        REG_START_DUTY = 3'd1,
        REG_RAMP_INIT  = 3'd2,
        REG_RAMP_DEC   = 3'd3,
        REG_RAMP_END   = 3'd4,
        REG_DEBOUNCE   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PHASE_W-1:0] high;
        logic [PHASE_W-1:0] low;
        logic [PHASE_W-1:0] sense;
    } t_phases;

    // six-step commutation table
    function automatic t_phases step_phases(input logic [STEP_W-1:0] step);
        t_phases p;
        case (step)
            3'd0:    p = '{high: PH_A, low: PH_B, sense: PH_C};
            3'd1:    p = '{high: PH_A, low: PH_C, sense: PH_B};
            3'd2:    p = '{high: PH_B, low: PH_C, sense: PH_A};
            3'd3:    p = '{high: PH_B, low: PH_A, sense: PH_C};
            3'd4:    p = '{high: PH_C, low: PH_A, sense: PH_B};
            3'd5:    p = '{high: PH_C, low: PH_B, sense: PH_A};
            default: p = '{high: PH_NONE, low: PH_NONE, sense: PH_NONE};
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sbc_if.sv =====
`default_nettype none
interface sbc_in_if;
    import sbc_pkg::*;
    logic               valid;
    logic               ready;
    logic               comparator_out;
    logic [SPEED_W-1:0] speed_command;

    modport source (output valid, output comparator_out, output speed_command, input ready);
    modport sink   (input valid, input comparator_out, input speed_command, output ready);
endinterface

interface sbc_out_if;
    import sbc_pkg::*;
    logic               valid;
    logic               ready;
    logic [PHASE_W-1:0] high_phase;
    logic [PHASE_W-1:0] low_phase;
    logic [PHASE_W-1:0] sense_phase;
    logic [DUTY_W-1:0]  duty_level;
    logic               commutated;
    logic               running;

    modport source (output valid, output high_phase, output low_phase, output sense_phase,
                    output duty_level, output commutated, output running, input ready);
    modport sink   (input valid, input high_phase, input low_phase, input sense_phase,
                    input duty_level, input commutated, input running, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbc_regs.sv =====
`default_nettype none
module sbc_regs #(
    parameter int DUTY_BITS  = sbc_pkg::DEF_DUTY_BITS,
    parameter int DELAY_BITS = sbc_pkg::DEF_DELAY_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sbc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [sbc_pkg::APB_DW-1:0]  pwdata,
    output logic      [sbc_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output logic      [DUTY_BITS-1:0]        o_min_duty,
    output logic      [DUTY_BITS-1:0]        o_start_duty,
    output logic      [DELAY_BITS-1:0]       o_ramp_decrement,
    output logic      [DELAY_BITS-1:0]       o_ramp_end,
    output logic      [sbc_pkg::MATCH_W-1:0] o_debounce_samples
);
    import sbc_pkg::*;

    logic [DUTY_BITS-1:0]  r_min_duty;
    logic [DUTY_BITS-1:0]  r_start_duty;
    logic [DELAY_BITS-1:0] r_ramp_init;
    logic [DELAY_BITS-1:0] r_ramp_dec;
    logic [DELAY_BITS-1:0] r_ramp_end;
    logic [MATCH_W-1:0]    r_debounce;
    t_reg_idx              reg_idx;
    logic                  wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // ramp_initial is only readable here: the ramp reloads from its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty   <= DUTY_BITS'(RST_MIN_DUTY);
            r_start_duty <= DUTY_BITS'(RST_START_DUTY);
            r_ramp_init  <= DELAY_BITS'(RST_RAMP_INIT);
            r_ramp_dec   <= DELAY_BITS'(RST_RAMP_DEC);
            r_ramp_end   <= DELAY_BITS'(RST_RAMP_END);
            r_debounce   <= MATCH_W'(RST_DEBOUNCE);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_DUTY:   r_min_duty   <= pwdata[DUTY_BITS-1:0];
                REG_START_DUTY: r_start_duty <= pwdata[DUTY_BITS-1:0];
                REG_RAMP_INIT:  r_ramp_init  <= pwdata[DELAY_BITS-1:0];
                REG_RAMP_DEC:   r_ramp_dec   <= pwdata[DELAY_BITS-1:0];
                REG_RAMP_END:   r_ramp_end   <= pwdata[DELAY_BITS-1:0];
                REG_DEBOUNCE:   r_debounce   <= pwdata[MATCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_DUTY:   prdata = APB_DW'(r_min_duty);
            REG_START_DUTY: prdata = APB_DW'(r_start_duty);
            REG_RAMP_INIT:  prdata = APB_DW'(r_ramp_init);
            REG_RAMP_DEC:   prdata = APB_DW'(r_ramp_dec);
            REG_RAMP_END:   prdata = APB_DW'(r_ramp_end);
            REG_DEBOUNCE:   prdata = APB_DW'(r_debounce);
            default:        prdata = '0;
        endcase
    end

    assign o_min_duty         = r_min_duty;
    assign o_start_duty       = r_start_duty;
    assign o_ramp_decrement   = r_ramp_dec;
    assign o_ramp_end         = r_ramp_end;
    assign o_debounce_samples = r_debounce;

endmodule
`default_nettype wire

// ===== rtl/sensorless_bldc_commutator.sv =====
// sensorless six-step bldc commutator
// i_tick (valid/ready): one transaction per motor tick, carrying the back-emf
// comparator sample and the speed command. o_res (valid/ready): one transaction
// per tick with the high, low and sense phase codes (3 = none), pwm duty,
// a commutation flag and the running flag.
// apb port: six 32-bit registers at byte addresses 0,4,..,20; writes take
// setup + access, pready is tied high, reads are combinational.
// an accepted tick waits in the input register until the result register is free,
// then its result is registered there and offered on o_res.
// throughput: one tick per cycle while o_res is not stalled, set by the single input
// register and the single result register with the state update between them.
// reset (synchronous, active low): registers return to defaults, the start
// ramp is armed with the reset ramp_initial, no phase is driven.
// a stalled receiver holds the result register; the input register still takes
// one more tick, after which i_tick.ready drops until o_res drains.
// writes to ramp_initial are stored and read back but never reload the ramp.
`default_nettype none
module sensorless_bldc_commutator #(
    parameter int DUTY_BITS  = sbc_pkg::DEF_DUTY_BITS,
    parameter int DELAY_BITS = sbc_pkg::DEF_DELAY_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    sbc_in_if.sink                          i_tick,
    sbc_out_if.source                       o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sbc_pkg::APB_AW-1:0] paddr,
    input  wire logic [sbc_pkg::APB_DW-1:0] pwdata,
    output logic      [sbc_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import sbc_pkg::*;

    // duty compare runs at the wider of command and duty widths
    localparam int CMP_W = (DUTY_BITS > SPEED_W) ? DUTY_BITS : SPEED_W;
    localparam logic [CMP_W-1:0] DUTY_MASK = CMP_W'({DUTY_BITS{1'b1}});

    // configuration
    logic [DUTY_BITS-1:0]  min_duty;
    logic [DUTY_BITS-1:0]  start_duty;
    logic [DELAY_BITS-1:0] ramp_dec;
    logic [DELAY_BITS-1:0] ramp_end;
    logic [MATCH_W-1:0]    debounce;

    sbc_regs #(
        .DUTY_BITS  (DUTY_BITS),
        .DELAY_BITS (DELAY_BITS)
    ) u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_min_duty         (min_duty),
        .o_start_duty       (start_duty),
        .o_ramp_decrement   (ramp_dec),
        .o_ramp_end         (ramp_end),
        .o_debounce_samples (debounce)
    );

    // input register
    logic               r_s1_valid;
    logic               r_s1_cmp;
    logic [SPEED_W-1:0] r_s1_speed;

    // commutation state
    logic [STEP_W-1:0]     r_next_step,   n_next_step;
    logic [STEP_W-1:0]     r_applied,     n_applied;
    logic                  r_drive_on,    n_drive_on;
    logic                  r_closed_loop, n_closed_loop;
    logic [DELAY_BITS-1:0] r_ramp_period, n_ramp_period;
    logic [DELAY_BITS-1:0] r_delay_left,  n_delay_left;
    logic [MATCH_W-1:0]    r_match_count, n_match_count;

    // result register
    logic               r_out_valid;
    t_phases            r_out_ph,   n_out_ph;
    logic [DUTY_W-1:0]  r_out_duty, n_out_duty;
    logic               r_out_com,  n_out_com;
    logic               r_out_run;

    logic                  ld_out;
    logic                  in_ready;
    logic                  do_com;
    logic [DELAY_BITS-1:0] shrunk;
    logic [MATCH_W-1:0]    need;
    logic [MATCH_W-1:0]    match_inc;
    logic [CMP_W-1:0]      speed_x;
    logic [CMP_W-1:0]      min_x;
    logic [CMP_W-1:0]      duty_x;

    // handshake: result register frees when empty or taken this cycle
    assign ld_out   = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_s1_valid || ld_out;
    assign i_tick.ready = in_ready;

    assign shrunk    = (r_ramp_period > ramp_dec) ? r_ramp_period - ramp_dec : '0;
    assign need      = (debounce == '0) ? MATCH_W'(1) : debounce;
    assign match_inc = r_match_count + MATCH_W'(1);

    // one tick of the commutation state machine
    always_comb begin
        n_next_step   = r_next_step;
        n_applied     = r_applied;
        n_drive_on    = r_drive_on;
        n_closed_loop = r_closed_loop;
        n_ramp_period = r_ramp_period;
        n_delay_left  = r_delay_left;
        n_match_count = r_match_count;
        do_com        = 1'b0;

        if (!r_closed_loop) begin
            if (r_ramp_period <= ramp_end) begin
                // ramp already short enough: hand over without commutating
                n_closed_loop = 1'b1;
                n_match_count = '0;
            end else if (r_delay_left != '0) begin
                n_delay_left = r_delay_left - DELAY_BITS'(1);
            end else begin
                do_com        = 1'b1;
                n_ramp_period = shrunk;
                n_delay_left  = shrunk;
                if (shrunk <= ramp_end) begin
                    n_closed_loop = 1'b1;
                    n_match_count = '0;
                end
            end
        end else if (r_s1_cmp == r_next_step[0]) begin
            // expected level: high on odd pending step, low on even
            if (match_inc >= need) begin
                do_com        = 1'b1;
                n_match_count = '0;
            end else begin
                n_match_count = match_inc;
            end
        end

        if (do_com) begin
            n_applied   = r_next_step;
            n_drive_on  = 1'b1;
            n_next_step = (r_next_step >= LAST_STEP) ? '0 : r_next_step + STEP_W'(1);
        end
    end

    // result payload
    assign speed_x = CMP_W'(r_s1_speed);
    assign min_x   = CMP_W'(min_duty);

    always_comb begin
        if (n_closed_loop) begin
            duty_x = (speed_x < min_x) ? min_x : speed_x;
        end else begin
            duty_x = CMP_W'(start_duty);
        end
        n_out_duty = DUTY_W'(duty_x & DUTY_MASK);
        n_out_com  = do_com;
        if (n_drive_on) begin
            n_out_ph = step_phases(n_applied);
        end else begin
            n_out_ph = '{high: PH_NONE, low: PH_NONE, sense: PH_NONE};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_next_step   <= '0;
            r_applied     <= '0;
            r_drive_on    <= 1'b0;
            r_closed_loop <= 1'b0;
            r_ramp_period <= DELAY_BITS'(RST_RAMP_INIT);
            r_delay_left  <= DELAY_BITS'(RST_RAMP_INIT);
            r_match_count <= '0;
        end else begin
            if (i_tick.valid && in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (ld_out) begin
                r_s1_valid <= 1'b0;
            end

            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (ld_out) begin
                r_next_step   <= n_next_step;
                r_applied     <= n_applied;
                r_drive_on    <= n_drive_on;
                r_closed_loop <= n_closed_loop;
                r_ramp_period <= n_ramp_period;
                r_delay_left  <= n_delay_left;
                r_match_count <= n_match_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_tick.valid && in_ready) begin
            r_s1_cmp   <= i_tick.comparator_out;
            r_s1_speed <= i_tick.speed_command;
        end
        if (ld_out) begin
            r_out_ph   <= n_out_ph;
            r_out_duty <= n_out_duty;
            r_out_com  <= n_out_com;
            r_out_run  <= n_closed_loop;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.high_phase  = r_out_ph.high;
    assign o_res.low_phase   = r_out_ph.low;
    assign o_res.sense_phase = r_out_ph.sense;
    assign o_res.duty_level  = r_out_duty;
    assign o_res.commutated  = r_out_com;
    assign o_res.running     = r_out_run;

`ifndef NO_ASSERTIONS
    // a commutation always leaves a driven phase pattern
    a_com_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.commutated) |-> (o_res.high_phase != PH_NONE))
        else $error("commutation reported with no phase driven");

    // closed loop is never left once entered
    a_loop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_closed_loop))
        else $error("closed loop dropped back to start ramp");

    // match counter only moves in closed loop
    a_match_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_closed_loop |-> (r_match_count == '0))
        else $error("match count moved during start ramp");

    // state only changes when a result is loaded
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!ld_out) && $past(i_rst_n) |-> $stable(r_delay_left) && $stable(r_next_step))
        else $error("commutation state changed without a tick");
`endif

endmodule
`default_nettype wire

// ===== sim/sbc_checker.sv =====
`default_nettype none
module sbc_checker
    import sbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbc_in_if                 i_tick,
    sbc_out_if                i_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output logic              o_idle,
    output int                o_mismatches
);

    localparam int DLY_W = DEF_DELAY_BITS;

    typedef struct packed {
        logic [PHASE_W-1:0] high;
        logic [PHASE_W-1:0] low;
        logic [PHASE_W-1:0] sense;
        logic [DUTY_W-1:0]  duty;
        logic               commutated;
        logic               running;
    } t_drive_word;

    // phases per step: high side, low side, floating
    localparam logic [PHASE_W-1:0] HIGH_SIDE [6] = '{PH_A, PH_A, PH_B, PH_B, PH_C, PH_C};
    localparam logic [PHASE_W-1:0] LOW_SIDE  [6] = '{PH_B, PH_C, PH_C, PH_A, PH_A, PH_B};
    localparam logic [PHASE_W-1:0] FLOATING  [6] = '{PH_C, PH_B, PH_A, PH_C, PH_B, PH_A};

    // register copies
    logic [DUTY_W-1:0]  min_duty_r;
    logic [DUTY_W-1:0]  start_duty_r;
    logic [DLY_W-1:0]   ramp_dec_r;
    logic [DLY_W-1:0]   ramp_end_r;
    logic [MATCH_W-1:0] debounce_r;

    // motor state
    logic [STEP_W-1:0]  pend_step;
    logic [STEP_W-1:0]  shown_step;
    logic               driving;
    logic               locked;
    logic [DLY_W-1:0]   ramp_len;
    logic [DLY_W-1:0]   ramp_wait;
    logic [MATCH_W-1:0] match_cnt;

    t_drive_word drive_words_due[$];
    int          fails = 0;

    task automatic advance_commutation();
        shown_step = pend_step;
        driving    = 1'b1;
        pend_step  = (pend_step == LAST_STEP) ? '0 : pend_step + STEP_W'(1);
    endtask

    task automatic tick_motor(input logic cmp, input logic [SPEED_W-1:0] speed,
                              output t_drive_word w);
        logic               fired;
        logic [MATCH_W-1:0] need;
        fired = 1'b0;
        if (!locked) begin
            if (ramp_len <= ramp_end_r) begin
                locked    = 1'b1;
                match_cnt = '0;
            end else if (ramp_wait != '0) begin
                ramp_wait = ramp_wait - DLY_W'(1);
            end else begin
                advance_commutation();
                fired     = 1'b1;
                ramp_len  = (ramp_len > ramp_dec_r) ? ramp_len - ramp_dec_r : '0;
                ramp_wait = ramp_len;
                if (ramp_len <= ramp_end_r) begin
                    locked    = 1'b1;
                    match_cnt = '0;
                end
            end
        end else if (cmp == pend_step[0]) begin
            need      = (debounce_r == '0) ? MATCH_W'(1) : debounce_r;
            match_cnt = match_cnt + MATCH_W'(1);
            if (match_cnt >= need) begin
                advance_commutation();
                fired     = 1'b1;
                match_cnt = '0;
            end
        end
        if (driving) begin
            w.high  = HIGH_SIDE[shown_step];
            w.low   = LOW_SIDE[shown_step];
            w.sense = FLOATING[shown_step];
        end else begin
            w.high  = PH_NONE;
            w.low   = PH_NONE;
            w.sense = PH_NONE;
        end
        if (locked) begin
            w.duty = (speed < min_duty_r) ? min_duty_r : speed;
        end else begin
            w.duty = start_duty_r;
        end
        w.commutated = fired;
        w.running    = locked;
    endtask

    always @(posedge i_clk) begin
        t_drive_word want;
        t_drive_word seen;
        if (!i_rst_n) begin
            min_duty_r   = DUTY_W'(RST_MIN_DUTY);
            start_duty_r = DUTY_W'(RST_START_DUTY);
            ramp_dec_r   = DLY_W'(RST_RAMP_DEC);
            ramp_end_r   = DLY_W'(RST_RAMP_END);
            debounce_r   = MATCH_W'(RST_DEBOUNCE);
            pend_step    = '0;
            shown_step   = '0;
            driving      = 1'b0;
            locked       = 1'b0;
            ramp_len     = DLY_W'(RST_RAMP_INIT);
            ramp_wait    = DLY_W'(RST_RAMP_INIT);
            match_cnt    = '0;
            drive_words_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen = '{high: i_res.high_phase, low: i_res.low_phase,
                         sense: i_res.sense_phase, duty: i_res.duty_level,
                         commutated: i_res.commutated, running: i_res.running};
                if (drive_words_due.size() == 0) begin
                    if (fails < 10)
                        $display({"unexpected result: hi=%0d lo=%0d sense=%0d",
                                  " duty=%0d com=%0b run=%0b"},
                                 seen.high, seen.low, seen.sense, seen.duty,
                                 seen.commutated, seen.running);
                    fails++;
                end else begin
                    want = drive_words_due.pop_front();
                    if (seen !== want) begin
                        if (fails < 10)
                            $display({"mismatch: exp hi=%0d lo=%0d sense=%0d duty=%0d",
                                      " com=%0b run=%0b | got hi=%0d lo=%0d sense=%0d",
                                      " duty=%0d com=%0b run=%0b"},
                                     want.high, want.low, want.sense, want.duty,
                                     want.commutated, want.running,
                                     seen.high, seen.low, seen.sense, seen.duty,
                                     seen.commutated, seen.running);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_MIN_DUTY:   min_duty_r   = pwdata[DUTY_W-1:0];
                    REG_START_DUTY: start_duty_r = pwdata[DUTY_W-1:0];
                    REG_RAMP_INIT:  ;  // never reloads the ramp: a reset uses the default
                    REG_RAMP_DEC:   ramp_dec_r   = pwdata[DLY_W-1:0];
                    REG_RAMP_END:   ramp_end_r   = pwdata[DLY_W-1:0];
                    REG_DEBOUNCE:   debounce_r   = pwdata[MATCH_W-1:0];
                    default:        ;
                endcase
            end
            if (i_tick.valid && i_tick.ready) begin
                tick_motor(i_tick.comparator_out, i_tick.speed_command, want);
                drive_words_due.push_back(want);
            end
        end
        o_idle       <= (drive_words_due.size() == 0);
        o_mismatches <= fails;
    end

endmodule
`default_nettype wire

// ===== sim/tb_sensorless_bldc_commutator.sv =====
`default_nettype none
module tb_sensorless_bldc_commutator;
    import sbc_pkg::*;

    // generous bound for about fourteen hundred ticks
    localparam int CYCLE_LIMIT = 200000;

    // register indexes that do not exist, writes must be ignored
    localparam logic [2:0] SPARE_IDX_LO = 3'd6;
    localparam logic [2:0] SPARE_IDX_HI = 3'd7;

    typedef enum logic [1:0] {
        RX_STREAM,  // always ready
        RX_COIN,    // ready on a coin toss
        RX_SPARSE,  // ready when rx_cyc is a multiple of four
        RX_BURSTY   // not ready while rx_cyc modulo 32 is below 12
    } t_rx_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic              chk_idle;
    int                chk_mismatches;

    logic              rx_ready = 1'b0;
    t_rx_mode          rx_mode  = RX_STREAM;
    int                rx_cyc   = 0;
    int                cycles   = 0;

    // sender state: burst budget and the comparator run in progress
    int                burst_left = 0;
    int                run_left   = 0;
    logic              cmp_level  = 1'b0;

    sbc_in_if  tick_if ();
    sbc_out_if res_if ();

    assign res_if.ready = rx_ready;

    sensorless_bldc_commutator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both channels and the register port, predicts and compares
    sbc_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_idle       (chk_idle),
        .o_mismatches (chk_mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sensorless_bldc_commutator test failed");
            $finish;
        end
    end

    // receiver back-pressure, the pattern is redrawn as rx_cyc passes each multiple of 64
    always @(posedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 64 == 0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_STREAM: rx_ready <= 1'b1;
            RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rx_ready <= (rx_cyc % 4 == 0);
            default:   rx_ready <= (rx_cyc % 32) >= 12;
        endcase
    end

    // one register write: setup, access until pready, then an idle gap with psel low
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // one tick transaction, opening a fresh burst after a random gap when due
    task automatic send_tick(input logic cmp, input logic [SPEED_W-1:0] speed);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        tick_if.valid          <= 1'b1;
        tick_if.comparator_out <= cmp;
        tick_if.speed_command  <= speed;
        do @(posedge i_clk); while (!tick_if.ready);
        burst_left--;
    endtask

    // back-emf like comparator: runs of one level sized around the debounce,
    // with the odd noisy sample thrown in
    task automatic drive_emf(input int count, input int deb);
        logic               cmp;
        logic [SPEED_W-1:0] speed;
        repeat (count) begin
            if (run_left == 0) begin
                cmp_level = ~cmp_level;
                run_left  = $urandom_range(1, 2 * deb + 2);
            end
            run_left--;
            cmp = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : cmp_level;
            case ($urandom_range(0, 9))
                0:       speed = '0;
                1:       speed = '1;
                default: speed = SPEED_W'($urandom_range(0, 1023));
            endcase
            send_tick(cmp, speed);
        end
    endtask

    // drop valid and wait for every outstanding result to drain
    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (!chk_idle);
    endtask

    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return DUTY_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // fresh register set for a random closed-loop phase
    task automatic shuffle_settings(output int deb);
        case ($urandom_range(0, 5))
            0:       deb = 0;
            1:       deb = 1;
            default: deb = $urandom_range(2, 16);
        endcase
        write_reg(REG_MIN_DUTY, APB_DW'(pick_duty()));
        write_reg(REG_START_DUTY, APB_DW'(pick_duty()));
        write_reg(REG_RAMP_INIT, APB_DW'(pick_delay()));
        write_reg(REG_RAMP_DEC, APB_DW'(pick_delay()));
        write_reg(REG_RAMP_END, APB_DW'(pick_delay()));
        write_reg(REG_DEBOUNCE, APB_DW'(deb));
        if ($urandom_range(0, 1))
            write_reg(SPARE_IDX_HI, $urandom());
    endtask

    initial begin
        int deb;
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        tick_if.valid          <= 1'b0;
        tick_if.comparator_out <= 1'b0;
        tick_if.speed_command  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start ramp counting down from the reset period of 5000,
        // well short of the first commutation
        write_reg(REG_RAMP_DEC, 32'd4000);
        write_reg(REG_RAMP_END, 32'd300);
        write_reg(REG_START_DUTY, 32'd1023);
        write_reg(REG_RAMP_INIT, 32'd7);  // must not reload the running ramp

        // no drive yet: phases read none, speed ignored while ramping
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b1, 10'd0);
        send_tick(1'b0, 10'd1023);
        drive_emf(296, 10);
        wait_idle();

        // duty change partway through the first wait
        write_reg(REG_START_DUTY, 32'd0);
        write_reg(REG_RAMP_INIT, 32'hFFFF);
        write_reg(SPARE_IDX_LO, 32'hFFFF_FFFF);
        drive_emf(200, 10);
        wait_idle();

        // end value raised to the ramp period: closed loop starts with no commutation
        write_reg(REG_RAMP_END, 32'd5000);
        write_reg(REG_START_DUTY, 32'd517);
        drive_emf(20, 10);
        wait_idle();

        // closed loop, single-sample debounce: alternating levels step every tick
        write_reg(REG_MIN_DUTY, 32'd0);
        write_reg(REG_DEBOUNCE, 32'd1);
        for (int i = 0; i < 8; i++)
            send_tick(1'(i), (i % 2 == 0) ? 10'd0 : 10'd1023);
        wait_idle();

        // debounce of zero behaves as one
        write_reg(REG_DEBOUNCE, 32'd0);
        for (int i = 0; i < 6; i++)
            send_tick(1'(i), SPEED_W'(i * 150));
        wait_idle();

        // duty floor at the top, wrong levels leave the match count alone
        write_reg(REG_MIN_DUTY, 32'd1023);
        write_reg(REG_DEBOUNCE, 32'd3);
        write_reg(REG_RAMP_END, 32'hFFFF);
        for (int i = 0; i < 6; i++)
            send_tick(1'(i), (i % 2 == 0) ? 10'd1023 : 10'd0);
        wait_idle();

        // floor right at the speed command
        write_reg(REG_MIN_DUTY, 32'd300);
        write_reg(REG_RAMP_END, 32'd0);
        send_tick(1'b0, 10'd299);
        send_tick(1'b1, 10'd300);
        send_tick(1'b0, 10'd301);
        wait_idle();

        // random closed-loop phases under shuffled settings
        repeat (5) begin
            shuffle_settings(deb);
            drive_emf(130, deb);
            wait_idle();
        end

        // widest debounce
        write_reg(REG_DEBOUNCE, 32'd255);
        drive_emf(250, 255);
        wait_idle();

        // let any stray result show itself
        repeat (8) @(posedge i_clk);
        if (chk_mismatches == 0 && chk_idle) begin
            $display("sensorless_bldc_commutator test passed");
        end else begin
            $display("sensorless_bldc_commutator test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
